/* rtl/core/mllw_pkg.sv */
package mllw_pkg;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  localparam int CH_W   = 4;
  localparam int TMO_W  = 13;
  localparam int CNT_W  = 16;
  localparam int MASK_W = 16;
  localparam int PH_W   = 10;
  localparam int DB_W   = 15;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] req_t;

  localparam mode_t MODE_TICK  = 2'd0;
  localparam mode_t MODE_FEED  = 2'd1;
  localparam mode_t MODE_FRAME = 2'd2;
  localparam mode_t MODE_LOAD  = 2'd3;

  localparam req_t REQ_NONE  = 2'd0;
  localparam req_t REQ_ERROR = 2'd1;
  localparam req_t REQ_LOST  = 2'd2;

  localparam logic [2:0] REG_IMU_CH      = 3'd0;
  localparam logic [2:0] REG_REMOTE_CH   = 3'd1;
  localparam logic [2:0] REG_MOTOR_FIRST = 3'd2;
  localparam logic [2:0] REG_MOTOR_LAST  = 3'd3;
  localparam logic [2:0] REG_GRACE       = 3'd4;
  localparam logic [2:0] REG_DEADBAND    = 3'd5;

  localparam logic [CH_W-1:0]  RST_IMU_CH      = 4'd0;
  localparam logic [CH_W-1:0]  RST_REMOTE_CH   = 4'd1;
  localparam logic [CH_W-1:0]  RST_MOTOR_FIRST = 4'd7;
  localparam logic [CH_W-1:0]  RST_MOTOR_LAST  = 4'd9;
  localparam logic [CNT_W-1:0] RST_GRACE       = 16'd2000;
  localparam logic [DB_W-1:0]  RST_DEADBAND    = 15'd3;
  localparam logic [TMO_W-1:0] RST_TIMEOUT     = 13'd1;

  localparam logic [CNT_W-1:0] SILENCE_CAP   = 16'hFFFE;
  localparam logic [CNT_W-1:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [PH_W-1:0]  PHASE_LAST    = 10'd999;

endpackage

/* rtl/core/multi_link_loss_watchdog_unit.sv */
// An accepted transaction is swept through the channel ring in state SWEEP, and its result
// is registered in state FINAL once the output is free; no new input is taken before that.
// The sweep passes the ring through the single counter and compare unit, one channel per cycle.
// The input side is ready again while a result still waits to be taken.
// Reset is synchronous and active low; it loads the counters, tables, configuration and state
// registers with their reset values at once; captured input and output data are not reset.
module multi_link_loss_watchdog_unit #(
  parameter int CHANNELS    = 16,
  parameter int LOSS_FACTOR = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // channel[3:0], timeout_cycles[16:4], key_word[32:17], mouse_x[48:33], zero fill
  input  logic [mllw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // mode[1:0]
  input  logic [mllw_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // lost_mask[15:0], request[17:16], armed[18], channel_rate[34:19], zero fill
  output logic [mllw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [mllw_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [mllw_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [mllw_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import mllw_pkg::*;

  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LF_W   = $clog2(LOSS_FACTOR + 1);
  localparam int PROD_W = TMO_W + LF_W;
  localparam int CMP_W  = (PROD_W > CNT_W) ? PROD_W : CNT_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);
  localparam logic [LF_W-1:0]  LF_VAL   = LF_W'(LOSS_FACTOR);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0] state_r, state_nxt;

  logic [CH_W-1:0]  imu_ch_r, remote_ch_r, motor_first_r, motor_last_r;
  logic [CNT_W-1:0] grace_r;
  logic [DB_W-1:0]  deadband_r;

  logic [CNT_W-1:0] sil_r [CHANNELS];
  logic [TMO_W-1:0] tmo_r [CHANNELS];
  logic [CNT_W-1:0] fc_r  [CHANNELS];
  logic [CNT_W-1:0] fr_r  [CHANNELS];

  logic [MASK_W-1:0] lost_r, lost_acc_r, lost_acc_nxt;
  logic              armed_r;
  logic [PH_W-1:0]   phase_r;
  logic [CNT_W-1:0]  uptime_r;

  mode_t            mode_r;
  logic [CH_W-1:0]  ch_r;
  logic [TMO_W-1:0] tmo_in_r;
  logic             latch_r;
  logic             active_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] rate_r, rate_nxt;

  logic              out_valid_r;
  logic [MASK_W-1:0] out_lost_r;
  req_t              out_req_r;
  logic              out_armed_r;
  logic [CNT_W-1:0]  out_rate_r;

  logic              in_acc, cfg_wr;
  mode_t             in_mode;
  logic [CH_W-1:0]   in_ch;
  logic [TMO_W-1:0]  in_tmo;
  logic [CNT_W-1:0]  in_key, in_mouse, mouse_mag;
  logic              in_active;

  logic [CNT_W-1:0]  sil_new, fc_new, fr_new;
  logic [TMO_W-1:0]  tmo_new;
  logic [PROD_W-1:0] limit;
  logic              head_hit, head_lost;

  logic [MASK_W-1:0] fin_lost;
  logic              motor_hit, imu_hit, remote_hit;
  req_t              fin_req;
  logic              fin_load;

  assign in_acc = in_tvalid && in_tready;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_pready = 1'b1;

  assign in_mode  = mode_t'(in_tuser[1:0]);
  assign in_ch    = in_tdata[3:0];
  assign in_tmo   = in_tdata[16:4];
  assign in_key   = in_tdata[32:17];
  assign in_mouse = in_tdata[48:33];
  assign mouse_mag = in_mouse[CNT_W-1] ? (~in_mouse + 16'd1) : in_mouse;
  assign in_active = (in_key != '0) || (mouse_mag > {1'b0, deadband_r});

  always_comb begin
    case (cfg_paddr[4:2])
      REG_IMU_CH:      cfg_prdata = CFG_DATA_W'(imu_ch_r);
      REG_REMOTE_CH:   cfg_prdata = CFG_DATA_W'(remote_ch_r);
      REG_MOTOR_FIRST: cfg_prdata = CFG_DATA_W'(motor_first_r);
      REG_MOTOR_LAST:  cfg_prdata = CFG_DATA_W'(motor_last_r);
      REG_GRACE:       cfg_prdata = CFG_DATA_W'(grace_r);
      REG_DEADBAND:    cfg_prdata = CFG_DATA_W'(deadband_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imu_ch_r      <= RST_IMU_CH;
      remote_ch_r   <= RST_REMOTE_CH;
      motor_first_r <= RST_MOTOR_FIRST;
      motor_last_r  <= RST_MOTOR_LAST;
      grace_r       <= RST_GRACE;
      deadband_r    <= RST_DEADBAND;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_IMU_CH:      imu_ch_r      <= cfg_pwdata[CH_W-1:0];
        REG_REMOTE_CH:   remote_ch_r   <= cfg_pwdata[CH_W-1:0];
        REG_MOTOR_FIRST: motor_first_r <= cfg_pwdata[CH_W-1:0];
        REG_MOTOR_LAST:  motor_last_r  <= cfg_pwdata[CH_W-1:0];
        REG_GRACE:       grace_r       <= cfg_pwdata[CNT_W-1:0];
        REG_DEADBAND:    deadband_r    <= cfg_pwdata[DB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The channel at the head of the ring passes through the shared update unit.
  assign head_hit = (ch_r == CH_W'(idx_r));
  assign limit    = PROD_W'(tmo_r[0]) * PROD_W'(LF_VAL);

  always_comb begin
    sil_new  = sil_r[0];
    tmo_new  = tmo_r[0];
    fc_new   = fc_r[0];
    fr_new   = fr_r[0];
    head_lost = 1'b0;
    case (mode_r)
      MODE_TICK: begin
        if (latch_r) begin
          fr_new = fc_r[0];
          fc_new = '0;
        end
        if (sil_r[0] < SILENCE_CAP) begin
          sil_new = sil_r[0] + 16'd1;
        end
        head_lost = CMP_W'(sil_new) > CMP_W'(limit);
      end
      MODE_FEED: begin
        if (head_hit) begin
          sil_new = '0;
        end
      end
      MODE_FRAME: begin
        if (head_hit && (fc_r[0] != COUNT_MAX)) begin
          fc_new = fc_r[0] + 16'd1;
        end
      end
      MODE_LOAD: begin
        if (head_hit) begin
          tmo_new = tmo_in_r;
        end
      end
      default: begin
      end
    endcase
    lost_acc_nxt = lost_acc_r | (head_lost ? (MASK_W'(1) << idx_r) : '0);
    rate_nxt = head_hit ? fr_new : rate_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sil_r[i] <= '0;
        tmo_r[i] <= RST_TIMEOUT;
        fc_r[i]  <= '0;
        fr_r[i]  <= '0;
      end
    end else if (state_r == ST_SWEEP) begin
      for (int i = 0; i < CHANNELS - 1; i++) begin
        sil_r[i] <= sil_r[i+1];
        tmo_r[i] <= tmo_r[i+1];
        fc_r[i]  <= fc_r[i+1];
        fr_r[i]  <= fr_r[i+1];
      end
      sil_r[CHANNELS-1] <= sil_new;
      tmo_r[CHANNELS-1] <= tmo_new;
      fc_r[CHANNELS-1]  <= fc_new;
      fr_r[CHANNELS-1]  <= fr_new;
    end
  end

  always_comb begin
    motor_hit = 1'b0;
    for (int j = 0; j < MASK_W; j++) begin
      if (lost_acc_r[j] && (CH_W'(j) >= motor_first_r) && (CH_W'(j) <= motor_last_r)) begin
        motor_hit = 1'b1;
      end
    end
    imu_hit    = lost_acc_r[imu_ch_r] && (uptime_r > grace_r);
    remote_hit = lost_acc_r[remote_ch_r];
    fin_req    = REQ_NONE;
    fin_lost   = lost_r;
    if (mode_r == MODE_TICK) begin
      fin_lost = lost_acc_r;
      if (remote_hit) begin
        fin_req = REQ_LOST;
      end else if (armed_r && (imu_hit || motor_hit)) begin
        fin_req = REQ_ERROR;
      end
    end
    fin_load = (state_r == ST_FINAL) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (fin_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      lost_r      <= '0;
      lost_acc_r  <= '0;
      armed_r     <= 1'b1;
      phase_r     <= '0;
      uptime_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        idx_r      <= '0;
        lost_acc_r <= '0;
        if (in_mode == MODE_TICK) begin
          phase_r <= (phase_r == PHASE_LAST) ? '0 : phase_r + 10'd1;
          if (uptime_r != COUNT_MAX) begin
            uptime_r <= uptime_r + 16'd1;
          end
        end
      end else if (state_r == ST_SWEEP) begin
        idx_r      <= idx_r + IDX_W'(1);
        lost_acc_r <= lost_acc_nxt;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
        if (mode_r == MODE_TICK) begin
          lost_r <= lost_acc_r;
          if (active_r) begin
            armed_r <= 1'b0;
          end
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r   <= in_mode;
      ch_r     <= in_ch;
      tmo_in_r <= in_tmo;
      latch_r  <= (in_mode == MODE_TICK) && (phase_r == '0);
      active_r <= in_active;
      rate_r   <= '0;
    end else if (state_r == ST_SWEEP) begin
      rate_r <= rate_nxt;
    end
    if (fin_load) begin
      out_lost_r  <= fin_lost;
      out_req_r   <= fin_req;
      out_armed_r <= armed_r && !((mode_r == MODE_TICK) && active_r);
      out_rate_r  <= rate_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_rate_r, out_armed_r, out_req_r, out_lost_r};

endmodule
